// File: src/nfsa_pkg.sv
// ----------------------------------------------------------------------------
// nfsa_pkg: shared types and constants for the next-fit slot allocator
// Holds the status codes, field widths and state machine encoding.
// ----------------------------------------------------------------------------
`default_nettype none
package nfsa_pkg;
  localparam int unsigned DefPoolSlots = 1024;
  localparam int unsigned WordW        = 32;
  localparam int unsigned SlotW        = 10;
  localparam int unsigned CountW       = 11;
  localparam int unsigned StatusW      = 2;

  typedef enum logic [StatusW-1:0] {
    ST_ALLOCATED = 2'd0,
    ST_EXHAUSTED = 2'd1,
    ST_RELEASED  = 2'd2,
    ST_BADINDEX  = 2'd3
  } status_e;

  typedef enum logic {
    OP_ALLOC   = 1'b0,
    OP_RELEASE = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_EVAL,
    S_OUT
  } state_e;
endpackage
`default_nettype wire

// File: src/next_fit_slot_allocator_core.sv
// Sequencing: an in-range release passes through the read and evaluate states to its
//   result, an out-of-range release goes straight to it; an allocate reads bitmap words until a
//   free slot is found or the search ends (start word read twice, one 32-slot word a read).
// Throughput: one item at a time; the next item is taken once the result leaves.
// Reset: asynchronous; afterwards a clearing pass writes every bitmap word, one
//   per cycle, during which no item is accepted.
// ----------------------------------------------------------------------------
// next_fit_slot_allocator_core: next-fit bitmap slot allocator
// Used bitmap lives in a word-wide RAM; read-modify-write per request with a
// word-by-word wrapping search from the next-fit pointer.
// ----------------------------------------------------------------------------
`default_nettype none
module next_fit_slot_allocator_core #(
  parameter int unsigned POOL_SLOTS = nfsa_pkg::DefPoolSlots
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic                         operation_i,
  input  wire logic [nfsa_pkg::SlotW-1:0]   slot_index_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [nfsa_pkg::StatusW-1:0]      status_o,
  output logic [nfsa_pkg::SlotW-1:0]        granted_slot_o,
  output logic [nfsa_pkg::CountW-1:0]       slots_in_use_o
);
  localparam int unsigned WordW  = nfsa_pkg::WordW;
  localparam int unsigned Words  = (POOL_SLOTS + WordW - 1) / WordW;
  localparam int unsigned AddrW  = (Words > 1) ? $clog2(Words) : 1;
  localparam int unsigned BitW   = $clog2(WordW);
  localparam int unsigned PtrW   = ($clog2(POOL_SLOTS) > BitW) ? $clog2(POOL_SLOTS) : BitW;
  localparam int unsigned CntW   = $clog2(POOL_SLOTS + 1);
  localparam int unsigned WCntW  = $clog2(Words + 2);

  // bitmap RAM, registered read
  logic [WordW-1:0] mem [Words];
  logic [WordW-1:0] rdata_q;
  logic             we;
  logic [AddrW-1:0] waddr, raddr;
  logic [WordW-1:0] wdata;

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rdata_q <= mem[raddr];
  end

  nfsa_pkg::state_e state_q, state_d;
  logic [AddrW-1:0] addr_q, addr_d;
  logic [WCntW-1:0] wcnt_q, wcnt_d;
  logic             first_q, first_d;
  logic             op_q;
  logic [nfsa_pkg::SlotW-1:0] idx_q;
  logic [PtrW-1:0]  start_q, start_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [nfsa_pkg::StatusW-1:0] st_q, st_d;
  logic [PtrW-1:0]  slot_q, slot_d;

  // valid slots in the word being examined: in pool, and at or after start on
  // the first visit, below start on the second visit of the start word
  logic [WordW-1:0] mask, cand, lowm;
  logic             found;
  logic [BitW-1:0]  bitpos;
  logic [PtrW+BitW:0] abs_slot;

  always_comb begin
    mask   = '0;
    lowm   = '0;
    bitpos = '0;
    for (int b = 0; b < WordW; b++) begin
      mask[b] = ((int'(addr_q) * WordW + b) < POOL_SLOTS);
      lowm[b] = (b < int'(start_q[BitW-1:0]));
    end
    cand = ~rdata_q & mask;
    // on the first visit of the start word the low part is searched last
    if (first_q && wcnt_q == '0) cand = cand & ~lowm;
    if (wcnt_q == WCntW'(Words)) cand = cand & lowm;
    found = |cand;
    for (int b = WordW - 1; b >= 0; b--) begin
      if (cand[b]) bitpos = BitW'(b);
    end
    abs_slot = {(PtrW+1)'(addr_q), bitpos};
  end

  logic [AddrW-1:0] rel_addr;
  logic [BitW-1:0]  rel_bit;
  assign rel_addr = AddrW'(idx_q >> BitW);
  assign rel_bit  = idx_q[BitW-1:0];

  always_comb begin
    state_d = state_q;
    addr_d  = addr_q;
    wcnt_d  = wcnt_q;
    first_d = first_q;
    start_d = start_q;
    count_d = count_q;
    st_d    = st_q;
    slot_d  = slot_q;
    we      = 1'b0;
    waddr   = addr_q;
    wdata   = '0;
    raddr   = addr_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      nfsa_pkg::S_CLEAR: begin
        we = 1'b1;
        if (addr_q == AddrW'(Words - 1)) begin
          state_d = nfsa_pkg::S_IDLE;
        end else begin
          addr_d = addr_q + 1'b1;
        end
      end
      nfsa_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        first_d    = 1'b1;
        wcnt_d     = '0;
        addr_d     = AddrW'(start_q >> BitW);
        if (in_valid_i) begin
          if (operation_i == nfsa_pkg::OP_RELEASE) begin
            addr_d = AddrW'(slot_index_i >> BitW);
            if (32'(slot_index_i) >= POOL_SLOTS) begin
              st_d    = nfsa_pkg::ST_BADINDEX;
              slot_d  = '0;
              state_d = nfsa_pkg::S_OUT;
            end else begin
              state_d = nfsa_pkg::S_READ;
            end
          end else begin
            state_d = nfsa_pkg::S_READ;
          end
        end
      end
      nfsa_pkg::S_READ: begin
        raddr   = addr_q;
        state_d = nfsa_pkg::S_EVAL;
      end
      nfsa_pkg::S_EVAL: begin
        if (op_q == nfsa_pkg::OP_RELEASE) begin
          we    = 1'b1;
          waddr = rel_addr;
          wdata = rdata_q & ~(WordW'(1) << rel_bit);
          if (rdata_q[rel_bit] && count_q != '0) count_d = count_q - 1'b1;
          st_d    = nfsa_pkg::ST_RELEASED;
          slot_d  = '0;
          state_d = nfsa_pkg::S_OUT;
        end else if (found) begin
          we      = 1'b1;
          wdata   = rdata_q | (WordW'(1) << bitpos);
          count_d = count_q + 1'b1;
          st_d    = nfsa_pkg::ST_ALLOCATED;
          slot_d  = PtrW'(abs_slot);
          start_d = (32'(abs_slot) + 1 >= POOL_SLOTS) ? '0 : PtrW'(abs_slot + 1'b1);
          state_d = nfsa_pkg::S_OUT;
        end else if (wcnt_q == WCntW'(Words)) begin
          st_d    = nfsa_pkg::ST_EXHAUSTED;
          slot_d  = '0;
          state_d = nfsa_pkg::S_OUT;
        end else begin
          // next word, wrapping; the start word is visited again at the end
          addr_d  = (addr_q == AddrW'(Words - 1)) ? '0 : addr_q + 1'b1;
          wcnt_d  = wcnt_q + 1'b1;
          first_d = 1'b0;
          state_d = nfsa_pkg::S_READ;
        end
      end
      nfsa_pkg::S_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = nfsa_pkg::S_IDLE;
      end
      default: state_d = nfsa_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= nfsa_pkg::S_CLEAR;
      addr_q  <= '0;
      wcnt_q  <= '0;
      first_q <= 1'b1;
      start_q <= '0;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      addr_q  <= addr_d;
      wcnt_q  <= wcnt_d;
      first_q <= first_d;
      start_q <= start_d;
      count_q <= count_d;
    end
  end

  // request and result payload
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      op_q  <= operation_i;
      idx_q <= slot_index_i;
    end
    st_q   <= st_d;
    slot_q <= slot_d;
  end

  assign status_o       = st_q;
  assign granted_slot_o = nfsa_pkg::SlotW'(slot_q);
  assign slots_in_use_o = nfsa_pkg::CountW'(count_q);
endmodule
`default_nettype wire

// File: src/nfsa_checker.sv
// ----------------------------------------------------------------------------
// nfsa_checker: port-level checks for the slot allocator
// Watches handshakes and result fields over time.
// ----------------------------------------------------------------------------
`default_nettype none
module nfsa_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [1:0]  status_o,
  input wire logic [9:0]  granted_slot_o,
  input wire logic [10:0] slots_in_use_o
);
  // no new transfer while a result is pending
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("input taken with result pending");

  // a result holds while stalled
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o)
      && $stable(slots_in_use_o)) else $error("result changed while stalled");

  // only a successful allocate carries a slot number
  a_slot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != nfsa_pkg::ST_ALLOCATED |-> granted_slot_o == '0)
    else $error("slot nonzero on non-allocate result");

  // a successful allocate leaves at least one slot in use
  a_alloc_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == nfsa_pkg::ST_ALLOCATED |-> slots_in_use_o != '0)
    else $error("allocate with zero in use");
endmodule

bind next_fit_slot_allocator_core nfsa_checker u_nfsa_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
  .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .status_o(status_o),
  .granted_slot_o(granted_slot_o), .slots_in_use_o(slots_in_use_o)
);
`default_nettype wire
